// ----- rtl/core/ffba_pkg.sv -----
// Package for the first-fit block allocator: field widths, operation and
// status codes, and the command and status words between controller and datapath.
// No dependencies.
package ffba_pkg;

  localparam int CELLS_DEFAULT       = 128;
  localparam int HANDLE_BITS_DEFAULT = 16;

  localparam int OP_W      = 2;
  localparam int AMOUNT_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int HANDLE_W  = 16;
  localparam int POOL_W    = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [POOL_W-1:0] POOL_RESET    = 8'd128;
  localparam logic              REG_POOL_SIZE = 1'b0;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEFRAG = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_e;

  typedef struct packed {
    logic    latch;
    logic    start;
    logic    clr_step;
    logic    eval;
    logic    advance;
    logic    take;
    logic    fill_step;
    logic    tail_load;
    logic    tail_step;
    logic    load_res;
    status_e res_status;
  } ffba_cmd_t;

  typedef struct packed {
    logic op_alloc;
    logic op_erase;
    logic lim_hit;
    logic pool_empty;
    logic amt_zero;
    logic rd_free;
    logic run_met;
    logic ptr_last;
    logic clr_last;
    logic cnt_last;
    logic dst_full;
    logic hit_next;
    logic out_free;
  } ffba_sts_t;

endpackage

// ----- rtl/core/ffba_ctrl.sv -----
// Controller of the first-fit block allocator: sequences the clearing pass,
// cell scans, fills, tail clears and result hand-off. Depends on ffba_pkg.
module ffba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ffba_pkg::ffba_sts_t  sts_i,
  output ffba_pkg::ffba_cmd_t  cmd_o
);
  import ffba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EV    = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_TAIL  = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  logic [2:0] state_q, state_d;
  status_e    res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      res_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    res_d          = res_q;
    cmd_o          = '0;
    cmd_o.res_status = res_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_START;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        priority if (sts_i.op_alloc) begin
          if (sts_i.lim_hit || sts_i.pool_empty) begin
            res_d   = ST_FAIL;
            state_d = S_RES;
          end else begin
            state_d = S_RD;
          end
        end else if (sts_i.op_erase) begin
          if (sts_i.amt_zero || sts_i.pool_empty) begin
            res_d   = ST_ILLEGAL;
            state_d = S_RES;
          end else begin
            state_d = S_RD;
          end
        end else begin
          state_d = sts_i.pool_empty ? S_IDLE : S_RD;
        end
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        cmd_o.eval = 1'b1;
        priority if (sts_i.op_alloc) begin
          if (sts_i.rd_free && sts_i.run_met) begin
            cmd_o.take = 1'b1;
            if (sts_i.amt_zero) begin
              res_d   = ST_OK;
              state_d = S_RES;
            end else begin
              state_d = S_FILL;
            end
          end else if (sts_i.ptr_last) begin
            res_d   = ST_FAIL;
            state_d = S_RES;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_RD;
          end
        end else if (sts_i.op_erase) begin
          if (sts_i.ptr_last) begin
            if (sts_i.hit_next) begin
              state_d = S_IDLE;
            end else begin
              res_d   = ST_ILLEGAL;
              state_d = S_RES;
            end
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_RD;
          end
        end else begin
          if (sts_i.ptr_last) begin
            if (sts_i.dst_full) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.tail_load = 1'b1;
              state_d         = S_TAIL;
            end
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.cnt_last) begin
          res_d   = ST_OK;
          state_d = S_RES;
        end
      end
      S_TAIL: begin
        cmd_o.tail_step = 1'b1;
        if (sts_i.ptr_last) state_d = S_IDLE;
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/ffba_dp.sv -----
// Datapath of the first-fit block allocator: cell memory, scan pointers,
// handle counter and output register. Depends on ffba_pkg.
module ffba_dp #(
  parameter int CELLS       = ffba_pkg::CELLS_DEFAULT,
  parameter int HANDLE_BITS = ffba_pkg::HANDLE_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ffba_pkg::POOL_W-1:0]     pool_size_i,
  input  logic [ffba_pkg::OP_W-1:0]       operation_i,
  input  logic [ffba_pkg::AMOUNT_W-1:0]   amount_i,
  input  ffba_pkg::ffba_cmd_t             cmd_i,
  output ffba_pkg::ffba_sts_t             sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [ffba_pkg::STATUS_W-1:0]   status_o,
  output logic [ffba_pkg::HANDLE_W-1:0]   handle_o
);
  import ffba_pkg::*;

  localparam int AddrW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CntW  = $clog2(CELLS + 1);
  localparam int CmpW  = (HANDLE_BITS > AMOUNT_W) ? HANDLE_BITS : AMOUNT_W;
  localparam int NW    = (CntW > POOL_W) ? CntW : POOL_W;

  logic [HANDLE_BITS-1:0] mem [CELLS];
  logic [HANDLE_BITS-1:0] rdata_q;

  logic [OP_W-1:0]        op_q;
  logic [AMOUNT_W-1:0]    amt_q;
  logic [CntW-1:0]        ptr_q, ptr_d;
  logic [CntW-1:0]        run_q, run_d;
  logic [CntW-1:0]        dst_q, dst_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   hit_q, hit_d;
  logic [HANDLE_BITS-1:0] last_q, last_d;
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [HANDLE_W-1:0]    handle_q;

  logic [NW-1:0]          pool_ext;
  logic [CntW-1:0]        n_cells, n_m1, run_inc, dst_next;
  logic [AMOUNT_W-1:0]    run_ext;
  logic [CmpW-1:0]        last_ext;
  logic                   op_alloc, op_erase, op_defrag;
  logic                   rd_free, rd_match;
  logic                   we;
  logic [CntW-1:0]        waddr;
  logic [HANDLE_BITS-1:0] wdata;

  assign pool_ext  = NW'(pool_size_i);
  assign n_cells   = (pool_ext > NW'(CELLS)) ? CntW'(CELLS) : pool_ext[CntW-1:0];
  assign n_m1      = n_cells - CntW'(1);
  assign op_alloc  = (op_q == OP_ALLOC);
  assign op_erase  = (op_q == OP_ERASE);
  assign op_defrag = !op_alloc && !op_erase;
  assign rd_free   = (rdata_q == '0);
  assign rd_match  = (CmpW'(rdata_q) == CmpW'(amt_q));
  assign run_inc   = run_q + CntW'(1);
  assign run_ext   = AMOUNT_W'(run_inc);
  assign dst_next  = dst_q + CntW'(!rd_free);
  assign last_ext  = CmpW'(last_q);

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = '0;
    priority if (cmd_i.clr_step || cmd_i.tail_step) begin
      we = 1'b1;
    end else if (cmd_i.fill_step) begin
      we    = 1'b1;
      wdata = last_q;
    end else if (cmd_i.eval && op_erase && rd_match) begin
      we = 1'b1;
    end else if (cmd_i.eval && op_defrag && !rd_free) begin
      we    = 1'b1;
      waddr = dst_q;
      wdata = rdata_q;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr[AddrW-1:0]] <= wdata;
    rdata_q <= mem[ptr_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= operation_i;
      amt_q <= amount_i;
    end
  end

  always_comb begin
    ptr_d  = ptr_q;
    run_d  = run_q;
    dst_d  = dst_q;
    cnt_d  = cnt_q;
    hit_d  = hit_q;
    last_d = last_q;
    if (cmd_i.start) begin
      ptr_d = '0;
      run_d = '0;
      dst_d = '0;
      hit_d = 1'b0;
    end
    if (cmd_i.eval) begin
      if (op_alloc) run_d = rd_free ? run_inc : '0;
      if (op_erase) hit_d = hit_q | rd_match;
      if (op_defrag) dst_d = dst_next;
    end
    if (cmd_i.advance || cmd_i.clr_step || cmd_i.tail_step) ptr_d = ptr_q + CntW'(1);
    if (cmd_i.take) begin
      ptr_d  = ptr_q - run_q;
      cnt_d  = amt_q[CntW-1:0];
      last_d = last_q + HANDLE_BITS'(1);
    end
    if (cmd_i.fill_step) begin
      ptr_d = ptr_q + CntW'(1);
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.tail_load) ptr_d = dst_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      run_q       <= '0;
      dst_q       <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      run_q  <= run_d;
      dst_q  <= dst_d;
      cnt_q  <= cnt_d;
      hit_q  <= hit_d;
      last_q <= last_d;
      if (cmd_i.load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      status_q <= cmd_i.res_status;
      handle_q <= (cmd_i.res_status == ST_OK) ? last_ext[HANDLE_W-1:0] : '0;
    end
  end

  assign sts_o.op_alloc   = op_alloc;
  assign sts_o.op_erase   = op_erase;
  assign sts_o.lim_hit    = &last_q;
  assign sts_o.pool_empty = (n_cells == '0);
  assign sts_o.amt_zero   = (amt_q == '0);
  assign sts_o.rd_free    = rd_free;
  assign sts_o.run_met    = (run_ext >= amt_q);
  assign sts_o.ptr_last   = (ptr_q == n_m1);
  assign sts_o.clr_last   = (ptr_q == CntW'(CELLS - 1));
  assign sts_o.cnt_last   = (cnt_q == CntW'(1));
  assign sts_o.dst_full   = (dst_next == n_cells);
  assign sts_o.hit_next   = hit_q | rd_match;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign handle_o    = handle_q;

endmodule

// ----- rtl/core/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: configuration port, controller
// and datapath. Depends on ffba_pkg, ffba_ctrl and ffba_dp.
//
// One command is worked at a time over a cell memory with one write port and
// one registered read port; each cell visited passes through a read state and
// an evaluate state. With n cells in use (pool_size, at most CELLS), allocate
// scans up to the cell that completes the first fitting run and then fills the
// run; erase and defragment scan all n cells, and defragment then clears the
// free tail behind the packed cells.
// A result waits in an output register while the next command is taken.
// After reset a clearing pass zeroes all CELLS cells of the memory and no
// command is taken until it ends; configuration writes are accepted throughout.
module first_fit_block_allocator #(
  parameter int CELLS       = ffba_pkg::CELLS_DEFAULT,
  parameter int HANDLE_BITS = ffba_pkg::HANDLE_BITS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0]   paddr,
  input  logic [ffba_pkg::PDATA_W-1:0]   pwdata,
  output logic [ffba_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ffba_pkg::OP_W-1:0]      operation_i,
  input  logic [ffba_pkg::AMOUNT_W-1:0]  amount_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ffba_pkg::STATUS_W-1:0]  status_o,
  output logic [ffba_pkg::HANDLE_W-1:0]  handle_o
);
  import ffba_pkg::*;

  logic [POOL_W-1:0] pool_size_q;
  logic              sel_pool;
  ffba_cmd_t         cmd;
  ffba_sts_t         sts;

  assign sel_pool = (paddr[PADDR_W-1:2] == REG_POOL_SIZE);
  assign pready   = 1'b1;
  assign prdata   = sel_pool ? PDATA_W'(pool_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= POOL_RESET;
    end else if (psel && penable && pwrite && sel_pool) begin
      pool_size_q <= pwdata[POOL_W-1:0];
    end
  end

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffba_dp #(
    .CELLS       (CELLS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pool_size_i (pool_size_q),
    .operation_i (operation_i),
    .amount_i    (amount_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .handle_o    (handle_o)
  );

endmodule
